// File: hw/rtl/cbts_pkg.sv
// ----------------------------------------------------------------------------
// cbts_pkg: shared types and constants for the CAN bit timing search
// Widths, search limits, microcode word layout and the control ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package cbts_pkg;

   localparam int unsigned CLK_W      = 28;
   localparam int unsigned BAUD_W     = 20;
   localparam int unsigned DIV_STEPS  = CLK_W;
   localparam int unsigned CNT_W      = $clog2(DIV_STEPS);
   localparam int unsigned SEG_W      = 5;
   localparam int unsigned QNT_W      = 6;
   localparam int unsigned PSC_W      = 4;
   localparam int unsigned BASE_W     = 10;
   localparam int unsigned PROD_W     = SEG_W + BASE_W;
   localparam int unsigned WORD_W     = 15;

   localparam logic [CLK_W-1:0] CLK_RESET = 28'd48000000;
   localparam logic [SEG_W-1:0] SEG_FIRST = 5'd3;
   localparam logic [SEG_W-1:0] SEG_LAST  = 5'd17;
   localparam logic [QNT_W-1:0] QNT_LAST  = 6'd32;
   localparam logic [PSC_W-1:0] PSC_LAST  = 4'd15;
   localparam logic [2:0]       SJW_MAX   = 3'd3;

   // program steps, in ROM order
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_INIT,
      ST_SCAN,
      ST_MISS,
      ST_HIT
   } step_type;

   typedef enum logic [2:0] {
      OP_LOAD,
      OP_DIV,
      OP_INIT,
      OP_SCAN,
      OP_MISS,
      OP_HIT
   } op_type;

   // sequencing: hold, fall through, or jump on a step-specific condition
   typedef enum logic [2:0] {
      CN_NEXT,
      CN_REQ,
      CN_DIV,
      CN_SCAN,
      CN_EMIT
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_type;

   function automatic ctrl_type ctrl_rom(step_type step);
      ctrl_type word;
      case (step)
         ST_IDLE: word = '{op: OP_LOAD, cond: CN_REQ,  target: ST_MISS};
         ST_DIV:  word = '{op: OP_DIV,  cond: CN_DIV,  target: ST_INIT};
         ST_INIT: word = '{op: OP_INIT, cond: CN_NEXT, target: ST_SCAN};
         ST_SCAN: word = '{op: OP_SCAN, cond: CN_SCAN, target: ST_HIT};
         ST_MISS: word = '{op: OP_MISS, cond: CN_EMIT, target: ST_IDLE};
         ST_HIT:  word = '{op: OP_HIT,  cond: CN_EMIT, target: ST_IDLE};
         default: word = '{op: OP_LOAD, cond: CN_NEXT, target: ST_IDLE};
      endcase
      return word;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/can_bit_timing_search.sv
// ----------------------------------------------------------------------------
// can_bit_timing_search: CAN prescaler / bit timing search
// Finds the first exact prescaler, quanta and segment split for a bit rate.
// ----------------------------------------------------------------------------
// A request word carries a bit rate. The block divides the peripheral clock
// register by it (truncated) to get clocks per bit, then walks prescaler
// 0..15, quanta 1..32, segments 3..17 (segments innermost) and stops at the
// first candidate whose segs*quanta*(prescaler+1) equals clocks per bit.
// One request is worked at a time; the next is taken once the result has
// entered the output register, so it may still wait there. In order: a load,
// a restoring divide over 28 bits (one quotient bit a cycle), a setup,
// a scan of one candidate per cycle (up to 16*32*15 = 7680), and the
// result write, which waits on a stalled output; zero rates skip to it.
// A zero bit rate or no exact match gives found = 0 with zero fields.
// The clock register is written over the csr port; write it only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module can_bit_timing_search
   import cbts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [23:0] req_tdata,   // [19:0] bit_rate, [23:20] zero
   // result stream
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [23:0] rsp_tdata,   // [3:0] prescaler, [18:4] timing_word, rest 0
   output      logic        rsp_tuser,   // [0] found
   // clock rate register write
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [27:0] csr_data     // peripheral_clock_hz
);

   // sequencer
   step_type step_ff, step_in;
   ctrl_type ctrl;

   // registers
   logic [CLK_W-1:0]  clk_hz_ff, clk_hz_in;
   logic [BAUD_W-1:0] baud_ff, baud_in;
   logic [CLK_W-1:0]  quo_ff, quo_in;      // dividend in, clocks per bit out
   logic [BAUD_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SEG_W-1:0]  seg_ff, seg_in;
   logic [QNT_W-1:0]  qnt_ff, qnt_in;
   logic [PSC_W-1:0]  psc_ff, psc_in;
   logic [BASE_W-1:0] base_ff, base_in;    // quanta * (prescaler + 1)
   logic              rsp_valid_ff, rsp_valid_in;
   logic              found_ff, found_in;
   logic [PSC_W-1:0]  rsp_psc_ff, rsp_psc_in;
   logic [WORD_W-1:0] rsp_word_ff, rsp_word_in;

   // datapath nets
   logic              req_fire;
   logic              out_busy;
   logic              emit;
   logic [BAUD_W:0]   trial;
   logic [BAUD_W:0]   diff;
   logic              ge;
   logic [PROD_W-1:0] prod;
   logic              hit;
   logic              last_cand;
   logic [3:0]        rest;
   logic [2:0]        seg1;
   logic [2:0]        seg2;
   logic [1:0]        sjw;
   logic [WORD_W-1:0] word;

   assign ctrl       = ctrl_rom(step_ff);
   assign req_tready = (ctrl.op == OP_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign out_busy   = rsp_valid_ff && !rsp_tready;
   assign emit       = ((ctrl.op == OP_HIT) || (ctrl.op == OP_MISS)) && !out_busy;
   assign csr_ready  = 1'b1;

   // restoring divider step
   assign trial = {rem_ff, quo_ff[CLK_W-1]};
   assign ge    = (trial >= {1'b0, baud_ff});
   assign diff  = trial - {1'b0, baud_ff};

   // candidate check: one small multiply and a compare
   assign prod      = seg_ff * base_ff;
   assign hit       = (quo_ff == {{(CLK_W-PROD_W){1'b0}}, prod});
   assign last_cand = (seg_ff == SEG_LAST) && (qnt_ff == QNT_LAST) && (psc_ff == PSC_LAST);

   // segment split of the held match
   assign rest = 4'(seg_ff - SEG_FIRST);
   assign seg1 = rest[3:1];
   assign seg2 = 3'(rest - {1'b0, seg1});
   assign sjw  = (seg1 > SJW_MAX) ? 2'(SJW_MAX) : seg1[1:0];
   assign word = {seg2, {1'b0, seg1}, sjw, 6'(qnt_ff - 6'd1)};

   // next step
   always_comb begin
      step_in = step_ff;
      case (ctrl.cond)
         CN_NEXT: step_in = step_type'(step_ff + 3'd1);
         CN_REQ: begin
            if (req_fire) begin
               step_in = (req_tdata[BAUD_W-1:0] == '0) ? ctrl.target
                                                        : step_type'(step_ff + 3'd1);
            end
         end
         CN_DIV: begin
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               step_in = step_type'(step_ff + 3'd1);
            end
         end
         CN_SCAN: begin
            if (hit) begin
               step_in = ctrl.target;
            end else if (last_cand) begin
               step_in = step_type'(step_ff + 3'd1);
            end
         end
         CN_EMIT: begin
            if (!out_busy) begin
               step_in = ctrl.target;
            end
         end
         default: step_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      clk_hz_in    = csr_valid ? csr_data : clk_hz_ff;
      baud_in      = baud_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      seg_in       = seg_ff;
      qnt_in       = qnt_ff;
      psc_in       = psc_ff;
      base_in      = base_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      found_in     = found_ff;
      rsp_psc_in   = rsp_psc_ff;
      rsp_word_in  = rsp_word_ff;
      case (ctrl.op)
         OP_LOAD: begin
            if (req_fire) begin
               baud_in = req_tdata[BAUD_W-1:0];
               quo_in  = clk_hz_ff;
               rem_in  = '0;
               cnt_in  = '0;
            end
         end
         OP_DIV: begin
            rem_in = ge ? diff[BAUD_W-1:0] : trial[BAUD_W-1:0];
            quo_in = {quo_ff[CLK_W-2:0], ge};
            cnt_in = cnt_ff + CNT_W'(1);
         end
         OP_INIT: begin
            seg_in  = SEG_FIRST;
            qnt_in  = QNT_W'(1);
            psc_in  = '0;
            base_in = BASE_W'(1);
         end
         OP_SCAN: begin
            // hold the candidate on a match
            if (!hit) begin
               if (seg_ff != SEG_LAST) begin
                  seg_in = seg_ff + SEG_W'(1);
               end else begin
                  seg_in = SEG_FIRST;
                  if (qnt_ff != QNT_LAST) begin
                     qnt_in  = qnt_ff + QNT_W'(1);
                     base_in = base_ff + BASE_W'(psc_ff) + BASE_W'(1);
                  end else begin
                     qnt_in  = QNT_W'(1);
                     psc_in  = psc_ff + PSC_W'(1);
                     base_in = BASE_W'(psc_ff) + BASE_W'(2);
                  end
               end
            end
         end
         OP_MISS: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               found_in     = 1'b0;
               rsp_psc_in   = '0;
               rsp_word_in  = '0;
            end
         end
         OP_HIT: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               found_in     = 1'b1;
               rsp_psc_in   = psc_ff;
               rsp_word_in  = word;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_tready;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         clk_hz_ff    <= CLK_RESET;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         clk_hz_ff    <= clk_hz_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      baud_ff     <= baud_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      seg_ff      <= seg_in;
      qnt_ff      <= qnt_in;
      psc_ff      <= psc_in;
      base_ff     <= base_in;
      found_ff    <= found_in;
      rsp_psc_ff  <= rsp_psc_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = found_ff;
   assign rsp_tdata  = {5'd0, rsp_word_ff, rsp_psc_ff};

endmodule

`default_nettype wire

// File: hw/rtl/cbts_checker.sv
// ----------------------------------------------------------------------------
// cbts_checker: port-level checks for the CAN bit timing search
// Watches the request and result streams of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cbts_checker
   import cbts_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [23:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic        rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // one request in flight: ready drops right after a request is taken
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while busy");

   // no match means all-zero fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 24'd0)
      else $error("miss result carries data");

   // seg2 is seg1 or seg1 + 1, seg1 below 8
   a_split: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         rsp_tdata[15] == 1'b0 &&
         (rsp_tdata[18:16] == rsp_tdata[14:12] ||
          rsp_tdata[18:16] == 3'(rsp_tdata[14:12] + 3'd1)))
      else $error("bad segment split");

   // a zero bit rate skips the divider but still counts as a request in flight
   a_zero_baud: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tdata[19:0] == 20'd0 |=> !req_tready)
      else $error("request taken right after a zero bit rate request");

endmodule

bind can_bit_timing_search cbts_checker u_cbts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
